[rtl/core/mmch_pkg.sv]
// Package for the modified MD5 container hash.
// Holds round constants, shift amounts, initial chain values and the sequencer state type.
// No dependencies.
package mmch_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_SHORT,
        BLK_SPLIT1,
        BLK_SPLIT2
    } blk_kind_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  SPLIT_POINT = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [3:0] idx);
        logic [4:0] s;
        unique case (idx)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/modified_md5_container_hash_top.sv]
// Top level of the modified MD5 container hash: byte intake, block buffer, round engine.
// Depends on mmch_pkg.
//
// One byte is taken per cycle while the sequencer is idle, not while a block is being
// compressed or a digest waits to be written out. Each 64th byte and the closing of a
// message start the shared round unit, which performs one MD5 round per cycle: 64
// rounds and then a fold step per block. The last byte is followed by one or two
// blocks and then the output step, after which the digest appears on the m_ channel;
// two blocks when the length modulo 64 is zero or at least 56, else one. The digest
// waits in a register until taken; the next message is taken meanwhile, and only its
// output step waits for that register to drain.
module modified_md5_container_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_low,
    output logic [63:0] m_digest_high
);

    mmch_pkg::state_t    state_reg, state_next;
    mmch_pkg::blk_kind_t kind_reg, kind_next;
    logic [31:0] buf_reg [16];
    logic [31:0] count_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] dl_reg, dh_reg;
    logic        busy_out_reg;
    logic        last_reg;

    logic        take;
    logic        out_free;
    logic [31:0] count_inc;
    logic [5:0]  r;
    logic [31:0] bits, tag;
    logic [1:0]  stage;
    logic [3:0]  g, g_prev;
    logic [31:0] f, m_word, sum, rot;
    logic [4:0]  sh;

    assign take      = s_valid && s_ready;
    assign out_free  = !busy_out_reg || m_ready;
    assign count_inc = count_reg + 32'd1;
    assign r         = count_reg[5:0];
    assign bits      = {count_reg[28:0], 3'b000};
    assign tag       = {2'b00, bits[31:2]} | 32'd1;
    assign s_ready   = (state_reg == mmch_pkg::ST_IDLE);
    assign m_valid   = busy_out_reg;
    assign m_digest_low  = dl_reg;
    assign m_digest_high = dh_reg;

    // tail bytes below r pass, byte r is the pad, the rest are zero
    function automatic logic [31:0] tail_word(input logic [3:0] w, input logic [31:0] raw,
                                              input logic [5:0] rr);
        logic [31:0] v;
        logic [5:0]  pos;
        v = 32'h0;
        for (int j = 0; j < 4; j++) begin
            pos = {w, 2'(j)};
            if (pos < rr) v[8*j +: 8] = raw[8*j +: 8];
            else if (pos == rr) v[8*j +: 8] = mmch_pkg::PAD_BYTE;
        end
        return v;
    endfunction

    always_comb begin
        stage = rnd_reg[5:4];
        unique case (stage)
            2'd0: begin f = (b_reg & c_reg) | (~b_reg & d_reg); g = rnd_reg[3:0]; end
            2'd1: begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2: begin f = b_reg ^ c_reg ^ d_reg; g = 4'(3 * rnd_reg[3:0] + 5); end
            default: begin f = c_reg ^ (b_reg | ~d_reg); g = 4'(7 * rnd_reg[3:0]); end
        endcase
        g_prev = g - 4'd1;
        m_word = 32'h0;
        unique case (kind_reg)
            mmch_pkg::BLK_DATA:   m_word = buf_reg[g];
            mmch_pkg::BLK_SPLIT1: m_word = tail_word(g, buf_reg[g], r);
            mmch_pkg::BLK_SPLIT2: begin
                if (g == 4'd0) m_word = bits;
                else if (g == 4'd15) m_word = tag;
            end
            mmch_pkg::BLK_SHORT: begin
                if (g == 4'd0) m_word = bits;
                else if (g == 4'd15) m_word = tag;
                else m_word = tail_word(g_prev, buf_reg[g_prev], r);
            end
            default: m_word = 32'h0;
        endcase
        sum = f + a_reg + mmch_pkg::round_k(rnd_reg) + m_word;
        sh  = mmch_pkg::round_s({stage, rnd_reg[1:0]});
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            mmch_pkg::ST_IDLE: begin
                if (take) begin
                    if (count_inc[5:0] == 6'd0) begin
                        state_next = mmch_pkg::ST_ROUND;
                        kind_next  = mmch_pkg::BLK_DATA;
                    end else if (s_is_last) begin
                        state_next = mmch_pkg::ST_ROUND;
                        kind_next  = (count_inc[5:0] >= mmch_pkg::SPLIT_POINT)
                                   ? mmch_pkg::BLK_SPLIT1 : mmch_pkg::BLK_SHORT;
                    end
                end
            end
            mmch_pkg::ST_ROUND: if (rnd_reg == 6'd63) state_next = mmch_pkg::ST_FOLD;
            mmch_pkg::ST_FOLD: begin
                priority if (kind_reg == mmch_pkg::BLK_SPLIT1) begin
                    state_next = mmch_pkg::ST_ROUND;
                    kind_next  = mmch_pkg::BLK_SPLIT2;
                end else if (kind_reg == mmch_pkg::BLK_DATA && last_reg) begin
                    state_next = mmch_pkg::ST_ROUND;
                    kind_next  = mmch_pkg::BLK_SHORT;
                end else if (kind_reg == mmch_pkg::BLK_DATA) begin
                    state_next = mmch_pkg::ST_IDLE;
                end else begin
                    state_next = mmch_pkg::ST_OUT;
                end
            end
            mmch_pkg::ST_OUT: if (out_free) state_next = mmch_pkg::ST_IDLE;
            default: state_next = mmch_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) buf_reg[count_reg[5:2]][8*count_reg[1:0] +: 8] <= s_data_byte;
        if (!aresetn) begin
            state_reg    <= mmch_pkg::ST_IDLE;
            kind_reg     <= mmch_pkg::BLK_DATA;
            count_reg    <= 32'd0;
            rnd_reg      <= 6'd0;
            last_reg     <= 1'b0;
            busy_out_reg <= 1'b0;
            ca_reg <= mmch_pkg::INIT_A; cb_reg <= mmch_pkg::INIT_B;
            cc_reg <= mmch_pkg::INIT_C; cd_reg <= mmch_pkg::INIT_D;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            if (state_reg == mmch_pkg::ST_OUT && out_free) busy_out_reg <= 1'b1;
            else if (m_ready) busy_out_reg <= 1'b0;
            if (take) begin
                count_reg <= count_inc;
                last_reg  <= s_is_last;
            end
            if (state_next == mmch_pkg::ST_ROUND && state_reg != mmch_pkg::ST_ROUND) begin
                rnd_reg <= 6'd0;
                if (state_reg == mmch_pkg::ST_IDLE) begin
                    a_reg <= ca_reg; b_reg <= cb_reg; c_reg <= cc_reg; d_reg <= cd_reg;
                end else begin
                    a_reg <= ca_reg + a_reg; b_reg <= cb_reg + b_reg;
                    c_reg <= cc_reg + c_reg; d_reg <= cd_reg + d_reg;
                end
            end
            if (state_reg == mmch_pkg::ST_ROUND) begin
                rnd_reg <= rnd_reg + 6'd1;
                a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg;
                b_reg <= b_reg + rot;
            end
            if (state_reg == mmch_pkg::ST_FOLD) begin
                ca_reg <= ca_reg + a_reg; cb_reg <= cb_reg + b_reg;
                cc_reg <= cc_reg + c_reg; cd_reg <= cd_reg + d_reg;
            end
            if (state_reg == mmch_pkg::ST_OUT && out_free) begin
                dl_reg <= {cb_reg, ca_reg};
                dh_reg <= {cd_reg, cc_reg};
                count_reg <= 32'd0;
                last_reg  <= 1'b0;
                ca_reg <= mmch_pkg::INIT_A; cb_reg <= mmch_pkg::INIT_B;
                cc_reg <= mmch_pkg::INIT_C; cd_reg <= mmch_pkg::INIT_D;
            end
        end
    end

endmodule

[rtl/core/mmch_checker.sv]
// Port-level checks for the modified MD5 container hash.
// Depends on modified_md5_container_hash_top; attached by bind.
module mmch_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_is_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_digest_low,
    input logic [63:0] m_digest_high
);

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_last |=> !s_ready [*65]) else $error("ready after last item");

    a_known_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_ready, m_valid})) else $error("handshake output unknown");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_low) && $stable(m_digest_high))
        else $error("result dropped");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result after reset");

endmodule

bind modified_md5_container_hash_top mmch_checker u_mmch_checker (.*);
